// ===== rtl/core/rrfp_pkg.sv =====
// Shared constants and types for the radar report frame parser.
`timescale 1ns / 1ps
`default_nettype none

package rrfp_pkg;

	// Default frame length in bytes, header through tail.
	localparam int unsigned FRAME_LEN_DEF = 45;

	// Frame header, in order of arrival.
	localparam logic [7:0] HDR_B0 = 8'hF4;
	localparam logic [7:0] HDR_B1 = 8'hF3;
	localparam logic [7:0] HDR_B2 = 8'hF2;
	localparam logic [7:0] HDR_B3 = 8'hF1;

	// Frame tail, in order of arrival.
	localparam logic [7:0] TAIL_B0 = 8'hF8;
	localparam logic [7:0] TAIL_B1 = 8'hF7;
	localparam logic [7:0] TAIL_B2 = 8'hF6;
	localparam logic [7:0] TAIL_B3 = 8'hF5;

	// Byte offsets of the reported fields inside a frame.
	localparam int unsigned OFS_PRESENCE = 6;
	localparam int unsigned OFS_DIST_LO  = 7;
	localparam int unsigned OFS_DIST_HI  = 8;

	// Result of evaluating the window against one new byte.
	typedef struct packed {
		logic        full;         // window holds a whole frame with the new byte
		logic        hit;          // header and tail both match
		logic [7:0]  presence;
		logic [15:0] distance_cm;
	} win_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrfp_window.sv =====
// Sliding byte window with fill count and header/tail frame match.
`timescale 1ns / 1ps
`default_nettype none

module rrfp_window #(
	parameter int unsigned FRAME_LEN = rrfp_pkg::FRAME_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        rx_byte,
	output rrfp_pkg::win_res_t     res
);

	localparam int unsigned HOLD = FRAME_LEN - 1;
	localparam int unsigned CW   = $clog2(FRAME_LEN);
	localparam logic [CW-1:0] FULL_CNT = CW'(HOLD);

	// The last FRAME_LEN-1 bytes, oldest at index 0. The incoming byte
	// completes the window as its final entry.
	logic [7:0]    line_q [HOLD];
	logic [CW-1:0] fill_q;
	logic          hdr_ok;
	logic          tail_ok;

	always_comb begin
		hdr_ok  = (line_q[0] == rrfp_pkg::HDR_B0) && (line_q[1] == rrfp_pkg::HDR_B1) &&
		          (line_q[2] == rrfp_pkg::HDR_B2) && (line_q[3] == rrfp_pkg::HDR_B3);
		tail_ok = (line_q[HOLD-3] == rrfp_pkg::TAIL_B0) &&
		          (line_q[HOLD-2] == rrfp_pkg::TAIL_B1) &&
		          (line_q[HOLD-1] == rrfp_pkg::TAIL_B2) &&
		          (rx_byte == rrfp_pkg::TAIL_B3);
		res.full        = (fill_q == FULL_CNT);
		res.hit         = res.full && hdr_ok && tail_ok;
		res.presence    = line_q[rrfp_pkg::OFS_PRESENCE];
		res.distance_cm = {line_q[rrfp_pkg::OFS_DIST_HI], line_q[rrfp_pkg::OFS_DIST_LO]};
	end

	// Stale bytes left behind after a frame are shifted out before the
	// count reaches full again, so the line needs no clearing.
	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < HOLD - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[HOLD-1] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step) begin
			if (res.full) begin
				fill_q <= res.hit ? '0 : FULL_CNT;
			end else begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/radar_report_frame_parser.sv =====
// Top level of the radar report frame parser: input stage, window, result register.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Received serial bytes arrive on the slave stream, one byte per transfer in
// s_tdata. The block keeps the most recent FRAME_LEN-1 bytes that have not been
// consumed by a frame. Once that many are held, each new byte is checked: if
// the oldest four bytes are the header F4 F3 F2 F1 and the newest four are the
// tail F8 F7 F6 F5, one result transfer goes out on the master stream and the
// window empties; otherwise the oldest byte is dropped and the search moves on.
// The byte that completes a frame is captured in the input register when it is
// accepted, and the result register loads, raising m_tvalid, when that byte is
// processed; a pending result can stall it in between. One byte is taken per
// cycle while the result register is free or drains. The input register
// takes a new byte while a result still waits in the output register; when the
// receiver holds m_tready low with a result pending, the input stage fills and
// s_tready then drops until the result is taken. Reset clears the fill count
// and both valid flags; the window bytes themselves are never read before they
// are written.
module radar_report_frame_parser #(
	parameter int unsigned FRAME_LEN = rrfp_pkg::FRAME_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave stream: received bytes.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Master stream: frame results.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // [7:0] presence, [23:8] distance_cm
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               m_valid_q;
	logic [23:0]        m_data_q;
	logic               adv;
	logic               step;
	rrfp_pkg::win_res_t win_res;

	// The input stage advances whenever the result register is free or drains.
	assign adv      = !m_valid_q || m_tready;
	assign step     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	rrfp_window #(
		.FRAME_LEN (FRAME_LEN)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (win_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= step && win_res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && win_res.hit) begin
			m_data_q <= {win_res.distance_cm, win_res.presence};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
	// A frame can only be recognized with a whole frame in the window.
	a_hit_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		win_res.hit |-> win_res.full)
		else $error("frame match without a full window");

	// A recognized frame empties the window.
	a_hit_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(step && win_res.hit) |=> !win_res.full)
		else $error("window still full after a frame was consumed");

	// A new result is loaded only by a byte processed in the cycle before.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && $past(adv)) |-> $past(step))
		else $error("result appeared without a processed byte");
`endif

endmodule

`default_nettype wire
